// ===== rtl/softmax_backward_fixed_core_macros.svh =====
// Assertion macros shared by the softmax backward core modules.
`ifndef SOFTMAX_BACKWARD_FIXED_CORE_MACROS_SVH
`define SOFTMAX_BACKWARD_FIXED_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SMBF_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SMBF_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/smbf_pkg.sv =====
// Shared codes, types and the float to Q16.16 conversion for the softmax backward core.
package smbf_pkg;

  // action codes
  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_EMIT  = 1'b1;

  // Q16.16 product on its way to the float converter
  typedef struct packed {
    logic [31:0] prod;
    logic        last;
  } smbf_prod_t;

  // IEEE single to Q16.16: truncate toward zero, saturate, NaN gives zero
  function automatic logic [31:0] to_q16(input logic [31:0] w);
    logic        neg;
    logic [7:0]  e;
    logic [23:0] m;
    logic [7:0]  lsw;
    logic [7:0]  rsw;
    logic [3:0]  ls;
    logic [4:0]  rs;
    logic [32:0] mag;
    logic [31:0] res;
    neg = w[31];
    e   = w[30:23];
    m   = {1'b1, w[22:0]};
    lsw = e - 8'd134;
    rsw = 8'd134 - e;
    ls  = lsw[3:0];
    rs  = rsw[4:0];
    // magnitude times 2^16; infinity lands in the saturating arm
    if (e >= 8'd143) begin
      mag = 33'h1_0000_0000;
    end else if (e >= 8'd134) begin
      mag = {9'd0, m} << ls;
    end else if (e >= 8'd111) begin
      mag = {9'd0, m >> rs};
    end else begin
      mag = 33'd0;
    end
    if (e == 8'hFF && w[22:0] != 23'd0) begin
      res = 32'd0;
    end else if (neg) begin
      res = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      res = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/smbf_dot_path.sv =====
// Input conversion, operand select, Q16.16 multiply and dot product accumulator.
`include "softmax_backward_fixed_core_macros.svh"

module smbf_dot_path
  import smbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] y_bits,
  input  logic [31:0] grad_bits,
  input  logic        first_of_vector,
  input  logic        last_of_vector,
  output logic        out_valid,
  input  logic        out_ready,
  output smbf_prod_t  out_item
);

  // stage 1: converted operands
  logic        v1;
  logic        act1;
  logic        first1;
  logic        last1;
  logic [31:0] yq1;
  logic [31:0] gq1;
  // stage 2: multiplier operands
  logic        v2;
  logic        act2;
  logic        first2;
  logic        last2;
  logic [31:0] y2;
  logic [31:0] b2;
  // stage 3: truncated product
  logic        v3;
  logic        act3;
  logic        first3;
  logic        last3;
  logic [31:0] prod3;
  // running dot product
  logic [31:0] dot_sum;

  logic               acc2;
  logic               acc3;
  logic               rdy1;
  logic               rdy2;
  logic               rdy3;
  logic               hold1;
  logic               mv12;
  logic               mv23;
  logic [31:0]        b2_next;
  logic signed [63:0] full_prod;

  // flow control; an emit waits until every earlier accumulate is in dot_sum
  assign acc2  = v2 && (act2 == ACT_ACCUM);
  assign acc3  = v3 && (act3 == ACT_ACCUM);
  assign rdy3  = !v3 || (act3 == ACT_ACCUM) || out_ready;
  assign rdy2  = !v2 || rdy3;
  assign hold1 = v1 && (act1 == ACT_EMIT) && (acc2 || acc3);
  assign mv12  = v1 && rdy2 && !hold1;
  assign rdy1  = !v1 || mv12;
  assign mv23  = v2 && rdy3;

  assign in_ready = rdy1;

  // emit multiplies y by g minus the finished dot product
  assign b2_next   = (act1 == ACT_EMIT) ? (gq1 - dot_sum) : gq1;
  assign full_prod = $signed(y2) * $signed(b2);

  // valid bits and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      dot_sum <= 32'd0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= mv12;
      if (rdy3) v3 <= mv23;
      if (acc3) dot_sum <= (first3 ? 32'd0 : dot_sum) + prod3;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      act1   <= action;
      first1 <= first_of_vector;
      last1  <= last_of_vector;
      yq1    <= to_q16(y_bits);
      gq1    <= to_q16(grad_bits);
    end
    if (mv12) begin
      act2   <= act1;
      first2 <= first1;
      last2  <= last1;
      y2     <= yq1;
      b2     <= b2_next;
    end
    if (mv23) begin
      act3   <= act2;
      first3 <= first2;
      last3  <= last2;
      prod3  <= full_prod[47:16];
    end
  end

  assign out_valid     = v3 && (act3 == ACT_EMIT);
  assign out_item.prod = prod3;
  assign out_item.last = last3;

  `SMBF_CHECK(a_no_acc_behind_emit, v2 && (act2 == ACT_EMIT), !acc3, "emit passed an accumulate")
  `SMBF_CHECK_NEXT(a_dot_only_on_acc, !acc3, $stable(dot_sum), "dot_sum moved without accumulate")
  `SMBF_CHECK(a_hold_blocks_move, hold1, !mv12, "emit left stage 1 during the interlock")

endmodule

// ===== rtl/smbf_to_float.sv =====
// Q16.16 to IEEE single conversion with round to nearest even and the output register.
`include "softmax_backward_fixed_core_macros.svh"

module smbf_to_float
  import smbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  smbf_prod_t  in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] grad_in_bits,
  output logic        last_out
);

  // stage 4: sign, magnitude, leading one position
  logic        v4;
  logic        sign4;
  logic [31:0] mag4;
  logic [4:0]  pos4;
  logic        zero4;
  logic        last4;
  // stage 5: result register
  logic        v5;
  logic [31:0] bits5;
  logic        last5;

  logic        rdy4;
  logic        rdy5;
  logic        sign_c;
  logic [31:0] mag_c;
  logic [4:0]  pos_c;
  logic [4:0]  shamt;
  logic [31:0] norm;
  logic [23:0] q;
  logic        round_up;
  logic [24:0] qr;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [31:0] bits_next;

  assign rdy5     = !v5 || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign in_ready = rdy4;

  // magnitude and leading one search
  assign sign_c = in_item.prod[31];
  assign mag_c  = sign_c ? (32'd0 - in_item.prod) : in_item.prod;

  always_comb begin
    pos_c = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag_c[i]) pos_c = 5'(i);
    end
  end

  // left-align, then round the 24-bit significand to nearest even
  assign shamt    = 5'd31 - pos4;
  assign norm     = mag4 << shamt;
  assign q        = norm[31:8];
  assign round_up = norm[7] && ((|norm[6:0]) || q[0]);
  assign qr       = {1'b0, q} + {24'd0, round_up};
  assign expo     = {3'd0, pos4} + 8'd111 + {7'd0, qr[24]};
  assign mant     = qr[24] ? 23'd0 : qr[22:0];
  assign bits_next = zero4 ? 32'd0 : {sign4, expo, mant};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy4) begin
      sign4 <= sign_c;
      mag4  <= mag_c;
      pos4  <= pos_c;
      zero4 <= (mag_c == 32'd0);
      last4 <= in_item.last;
    end
    if (v4 && rdy5) begin
      bits5 <= bits_next;
      last5 <= last4;
    end
  end

  assign out_valid    = v5;
  assign grad_in_bits = bits5;
  assign last_out     = last5;

  `SMBF_CHECK(a_lead_one, v4 && !zero4, mag4[pos4], "leading one position is wrong")
  `SMBF_CHECK(a_no_neg_zero, v5 && (bits5[30:0] == 31'd0), !bits5[31], "negative zero result")
  `SMBF_CHECK_NEXT(a_out_hold, v5 && out_stall, v5 && $stable(bits5), "stalled result moved")

endmodule

// ===== rtl/softmax_backward_fixed_core.sv =====
// Top level of the two-pass Q16.16 softmax gradient core.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_stall  | action, y_bits, grad_bits, first_of_vector,
//          |                      | last_of_vector
//  out     | out_valid / out_stall| grad_in_bits, last_out
//
// One item per cycle enters while in_stall is low; an emit result leaves registered.
// The first emit after accumulates waits in stage 1 until the last product is in
// the dot accumulator (multiply stage feeding the accumulator add).
// Accumulate items give no result; they retire from the multiply stage.
// rst clears every stage valid and the dot product.
// out_stall backs up through the stages; in_stall rises only when stage 1 cannot move.
module softmax_backward_fixed_core
  import smbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] y_bits,
  input  logic [31:0] grad_bits,
  input  logic        first_of_vector,
  input  logic        last_of_vector,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] grad_in_bits,
  output logic        last_out
);

  logic       in_ready;
  logic       prod_valid;
  logic       prod_ready;
  smbf_prod_t prod_item;

  assign in_stall = !in_ready;

  // conversion, multiply and accumulate
  smbf_dot_path u_dot_path (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .y_bits          (y_bits),
    .grad_bits       (grad_bits),
    .first_of_vector (first_of_vector),
    .last_of_vector  (last_of_vector),
    .out_valid       (prod_valid),
    .out_ready       (prod_ready),
    .out_item        (prod_item)
  );

  // fixed to float and output register
  smbf_to_float u_to_float (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (prod_valid),
    .in_ready     (prod_ready),
    .in_item      (prod_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grad_in_bits (grad_in_bits),
    .last_out     (last_out)
  );

endmodule

// ===== tb/softmax_grad_checker.sv =====
// Checker for the softmax backward core: predicts the gradient stream and compares transfers.
module softmax_grad_checker
  import smbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [31:0] y_bits,
  input  logic [31:0] grad_bits,
  input  logic        first_of_vector,
  input  logic        last_of_vector,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] grad_in_bits,
  input  logic        last_out,
  output int unsigned grad_pending,
  output int unsigned grad_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] bits;
    logic        last;
  } grad_item_t;

  grad_item_t  grad_q[$];
  logic [31:0] dot_acc = 32'd0;
  int unsigned err_cnt = 0;

  // IEEE single to Q16.16, truncating toward zero with saturation
  function automatic logic [31:0] float_to_q16(logic [31:0] w);
    logic [7:0]  ex;
    logic [23:0] man;
    logic [32:0] mag;
    int          shift;
    ex  = w[30:23];
    man = {1'b1, w[22:0]};
    if (ex == 8'hFF && w[22:0] != 23'd0) return 32'd0;
    if (ex == 8'd0) return 32'd0;
    shift = int'(ex) - 134;
    if (shift >= 9) begin
      mag = 33'h1_0000_0000;
    end else if (shift >= 0) begin
      mag = {9'd0, man} << shift;
    end else if (shift > -24) begin
      mag = {9'd0, man >> (-shift)};
    end else begin
      mag = 33'd0;
    end
    if (w[31]) return (mag > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    return (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // Q16.16 product: full 64-bit product, arithmetic shift by 16, low word kept
  function automatic logic [31:0] q16_mul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return p[47:16];
  endfunction

  // Q16.16 to IEEE single, round to nearest even
  function automatic logic [31:0] q16_to_float(logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] rem;
    logic [31:0] half;
    logic [24:0] q;
    int          msb;
    int          sh;
    mag = v[31] ? (32'd0 - v) : v;
    if (mag == 32'd0) return 32'd0;
    msb = 31;
    while (!mag[msb]) msb--;
    if (msb <= 23) begin
      q = 25'(mag << (23 - msb));
    end else begin
      sh   = msb - 23;
      rem  = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      q    = 25'(mag >> sh);
      if (rem > half || (rem == half && q[0])) q = q + 25'd1;
      if (q[24]) begin
        q   = q >> 1;
        msb = msb + 1;
      end
    end
    return {v[31], 8'(msb + 111), q[22:0]};
  endfunction

  task automatic note_error(string what, logic [31:0] want_v, logic [31:0] got_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t: %s mismatch, expected %08h got %08h", $realtime, what, want_v, got_v);
  endtask

  // track the dot product on input transfers, compare on output transfers
  always @(posedge clk) begin
    grad_item_t  want;
    logic [31:0] yq;
    logic [31:0] gq;
    if (rst) begin
      dot_acc = 32'd0;
      grad_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        yq = float_to_q16(y_bits);
        gq = float_to_q16(grad_bits);
        if (action == ACT_ACCUM) begin
          if (first_of_vector) dot_acc = 32'd0;
          dot_acc = dot_acc + q16_mul(yq, gq);
        end else begin
          want.bits = q16_to_float(q16_mul(yq, gq - dot_acc));
          want.last = last_of_vector;
          grad_q.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (grad_q.size() == 0) begin
          note_error("unexpected result", 32'd0, grad_in_bits);
        end else begin
          want = grad_q.pop_front();
          if (grad_in_bits !== want.bits) note_error("grad_in_bits", want.bits, grad_in_bits);
          if (last_out !== want.last)
            note_error("last_out", {31'd0, want.last}, {31'd0, last_out});
        end
      end
    end
    grad_pending <= grad_q.size();
    grad_errors  <= err_cnt;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the softmax backward core: clock, reset, stimulus and verdict.
module tb
  import smbf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = ACT_ACCUM;
  logic [31:0] y_bits = 32'd0;
  logic [31:0] grad_bits = 32'd0;
  logic        first_of_vector = 1'b0;
  logic        last_of_vector = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] grad_in_bits;
  logic        last_out;

  int unsigned grad_pending;
  int unsigned grad_errors;

  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  softmax_backward_fixed_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .y_bits          (y_bits),
    .grad_bits       (grad_bits),
    .first_of_vector (first_of_vector),
    .last_of_vector  (last_of_vector),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .grad_in_bits    (grad_in_bits),
    .last_out        (last_out)
  );

  softmax_grad_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .y_bits          (y_bits),
    .grad_bits       (grad_bits),
    .first_of_vector (first_of_vector),
    .last_of_vector  (last_of_vector),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .grad_in_bits    (grad_in_bits),
    .last_out        (last_out),
    .grad_pending    (grad_pending),
    .grad_errors     (grad_errors)
  );

  // receiver back-pressure: phases of free flow, random, heavy and toggling stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  // float words: mostly in the useful Q16.16 range, some specials and raw bits
  function automatic logic [31:0] rand_word(bit prob_like);
    logic        sgn;
    logic [22:0] man;
    sgn = 1'($urandom_range(0, 1));
    man = 23'($urandom());
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 7))
          0: return 32'h7F80_0000;
          1: return 32'hFF80_0000;
          2: return {sgn, 8'hFF, man | 23'd1};
          3: return {sgn, 8'd0, man};
          4: return {sgn, 31'd0};
          5: return {sgn, 8'($urandom_range(143, 254)), man};
          6: return {sgn, 8'($urandom_range(1, 110)), man};
          default: return {sgn, 8'($urandom_range(141, 142)), man};
        endcase
      end
      2, 3, 4: return {sgn, 8'($urandom_range(100, 145)), man};
      default: begin
        if (prob_like) return {1'b0, 8'($urandom_range(112, 126)), man};
        return {sgn, 8'($urandom_range(118, 131)), man};
      end
    endcase
  endfunction

  // one input transfer, with random gaps between bursts
  task automatic send_item(logic act, logic [31:0] yw, logic [31:0] gw, logic f, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        <= 1'b1;
    action          <= act;
    y_bits          <= yw;
    grad_bits       <= gw;
    first_of_vector <= f;
    last_of_vector  <= l;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  // hold the sender until every pending result has come out
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (grad_pending != 0);
  endtask

  // accumulate pass then emit pass over one random vector
  task automatic run_vector();
    logic [31:0] yv[$];
    logic [31:0] gv[$];
    int          len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      yv.push_back(rand_word(1'b1));
      gv.push_back(rand_word(1'b0));
    end
    for (int i = 0; i < len; i++)
      send_item(ACT_ACCUM, yv[i], gv[i], i == 0, i == len - 1);
    for (int i = 0; i < len; i++)
      send_item(ACT_EMIT, yv[i], ($urandom_range(0, 7) == 0) ? rand_word(1'b0) : gv[i],
                (i == 0) ^ ($urandom_range(0, 7) == 0), i == len - 1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: emit straight after reset, specials, saturation and wrap
    send_item(ACT_EMIT,  32'h3F80_0000, 32'h4040_0000, 1'b0, 1'b0);
    send_item(ACT_ACCUM, 32'h3F80_0000, 32'h4000_0000, 1'b1, 1'b0);
    send_item(ACT_ACCUM, 32'h3F00_0000, 32'h7FC0_0000, 1'b0, 1'b1);
    send_item(ACT_EMIT,  32'h3F80_0000, 32'h7F80_0000, 1'b1, 1'b0);
    send_item(ACT_EMIT,  32'hFF80_0000, 32'h0000_0001, 1'b0, 1'b0);
    send_item(ACT_EMIT,  32'h8000_0000, 32'h7F7F_FFFF, 1'b0, 1'b0);
    send_item(ACT_EMIT,  32'h4700_0000, 32'hC700_0000, 1'b0, 1'b0);
    send_item(ACT_EMIT,  32'h3780_0000, 32'h3F80_0000, 1'b0, 1'b0);
    send_item(ACT_EMIT,  32'h3700_0000, 32'hBF80_0000, 1'b0, 1'b1);
    send_item(ACT_ACCUM, 32'h46FF_FFFE, 32'h46FF_FFFE, 1'b1, 1'b1);
    send_item(ACT_ACCUM, 32'hC6FF_FFFE, 32'h46FF_FFFE, 1'b0, 1'b1);
    send_item(ACT_EMIT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    send_item(ACT_EMIT,  32'h3F80_0000, 32'hFF80_0000, 1'b0, 1'b1);
    send_item(ACT_EMIT,  32'h7F7F_FFFF, 32'h8000_0001, 1'b1, 1'b1);
    send_item(ACT_ACCUM, 32'h807F_FFFF, 32'h3F80_0000, 1'b1, 1'b0);
    send_item(ACT_EMIT,  32'h3F00_0000, 32'h3EAA_AAAB, 1'b0, 1'b1);
    send_item(ACT_EMIT,  32'h4300_0000, 32'h4300_0001, 1'b0, 1'b0);
    send_item(ACT_EMIT,  32'hC700_0001, 32'h4700_0001, 1'b0, 1'b1);
    drain_results();

    // random vectors with some noise and broken passes in between
    items_sent = 0;
    while (items_sent < 750) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), rand_word(1'b0), rand_word(1'b0),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        run_vector();
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (grad_errors == 0 && grad_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== softmax_backward_fixed_core.f =====
+incdir+rtl
rtl/smbf_pkg.sv
rtl/smbf_dot_path.sv
rtl/smbf_to_float.sv
rtl/softmax_backward_fixed_core.sv
tb/softmax_grad_checker.sv
tb/tb.sv
